### rtl/core/fqd_pkg.sv
// ---------------------------------------------------------------------------
// fqd_pkg: shared types and constants for the queue with delete
// Command and status codes, transaction payloads and the per-cell control
// bundle used by the cell row of fifo_queue_with_delete_top.
// ---------------------------------------------------------------------------
package fqd_pkg;

    // queue geometry
    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // input transaction
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] item_value;
    } fqd_in_t;

    // result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } fqd_out_t;

    // control broadcast to every cell
    typedef struct packed {
        logic              commit;
        logic              put_en;
        logic              get_en;
        logic              del_en;
        logic [DATA_W-1:0] value;
    } fqd_ctrl_t;

endpackage

### rtl/core/fqd_cell.sv
// ---------------------------------------------------------------------------
// fqd_cell: one queue slot
// Holds one entry, compares it against the delete key, passes the
// first-match flag to the younger neighbor and shifts in its younger
// neighbor's entry on get or on delete at or after the match.
// ---------------------------------------------------------------------------
module fqd_cell (
    input  logic                       aclk,
    input  fqd_pkg::fqd_ctrl_t         ctrl,
    input  logic                       occupied,
    input  logic                       wr_sel,
    input  logic                       found_in,
    input  logic [fqd_pkg::DATA_W-1:0] right_data,
    output logic                       found_out,
    output logic [fqd_pkg::DATA_W-1:0] data_out
);

    logic [fqd_pkg::DATA_W-1:0] data_reg;
    logic [fqd_pkg::DATA_W-1:0] data_next;
    logic                       hit;
    logic                       shift;

    // match against the delete key, first match wins down the chain
    assign hit       = ctrl.del_en & occupied & (data_reg == ctrl.value);
    assign found_out = found_in | hit;

    // shift toward the old end on get, or past the deleted entry
    assign shift = ctrl.commit & (ctrl.get_en | (ctrl.del_en & found_out));

    always_comb begin
        data_next = data_reg;
        if (shift) begin
            data_next = right_data;
        end else if (ctrl.commit & ctrl.put_en & wr_sel) begin
            data_next = ctrl.value;
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### rtl/core/fifo_queue_with_delete_top.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_delete_top: bounded queue with delete by value
// Row of cells, oldest at cell 0. Put appends, get pops the oldest entry,
// delete removes the first matching entry and closes the gap.
//
//   channel | ports                       | payload
//   --------+-----------------------------+---------------------------------
//   input   | s_valid, s_ready, s_data    | cmd, item_value
//   result  | m_valid, m_ready, m_data    | result_value, status, occupancy
//
// The compare chain through the cell row and the shift of every cell settle
// within the accepting cycle. One result per command, held in an output
// register that is loaded when the command is accepted. A new command is
// taken when no result is held or while the held result is taken (m_ready).
// Reset clears the fill count and the output valid; entries need none.
// ---------------------------------------------------------------------------
module fifo_queue_with_delete_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fqd_pkg::fqd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fqd_pkg::fqd_out_t m_data
);

    logic [fqd_pkg::CNT_W-1:0]  count_reg;
    logic [fqd_pkg::CNT_W-1:0]  count_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    fqd_pkg::fqd_out_t          m_data_reg;
    fqd_pkg::fqd_out_t          m_data_next;

    fqd_pkg::fqd_ctrl_t         ctrl;
    logic                       accept;
    logic                       full;
    logic                       empty;
    logic [fqd_pkg::DEPTH-1:0]  found;
    logic [fqd_pkg::DEPTH-1:0]  occupied;
    logic [fqd_pkg::DEPTH-1:0]  wr_sel;
    logic [fqd_pkg::DATA_W-1:0] cell_data [fqd_pkg::DEPTH];
    logic [fqd_pkg::DATA_W-1:0] res_value;
    logic [fqd_pkg::STAT_W-1:0] status;

    // handshake
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign full    = (count_reg == fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
    assign empty   = (count_reg == '0);

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < fqd_pkg::DEPTH; gi++) begin : g_cell
            logic                       found_prev;
            logic [fqd_pkg::DATA_W-1:0] right;

            assign occupied[gi] = (fqd_pkg::CNT_W'(gi) < count_reg);
            assign wr_sel[gi]   = (fqd_pkg::CNT_W'(gi) == count_reg);

            if (gi == 0) begin : g_head
                assign found_prev = 1'b0;
            end else begin : g_body
                assign found_prev = found[gi-1];
            end

            if (gi == fqd_pkg::DEPTH - 1) begin : g_tail
                assign right = cell_data[gi];
            end else begin : g_mid
                assign right = cell_data[gi+1];
            end

            fqd_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occupied[gi]),
                .wr_sel     (wr_sel[gi]),
                .found_in   (found_prev),
                .right_data (right),
                .found_out  (found[gi]),
                .data_out   (cell_data[gi])
            );
        end
    endgenerate

    // command decode to the cell row
    always_comb begin
        ctrl        = '0;
        ctrl.commit = accept;
        ctrl.value  = s_data.item_value;
        unique case (s_data.cmd)
            fqd_pkg::CMD_PUT: begin
                ctrl.put_en = ~full;
            end
            fqd_pkg::CMD_GET: begin
                ctrl.get_en = ~empty;
            end
            fqd_pkg::CMD_DEL: begin
                ctrl.del_en = 1'b1;
            end
            default: begin
                ctrl.put_en = 1'b0;
            end
        endcase
    end

    // result and next fill count
    always_comb begin
        res_value   = '0;
        status      = fqd_pkg::ST_OK;
        count_next  = count_reg;
        unique case (s_data.cmd)
            fqd_pkg::CMD_PUT: begin
                if (full) begin
                    status = fqd_pkg::ST_FULL;
                end else begin
                    count_next  = count_reg + 1'b1;
                end
            end
            fqd_pkg::CMD_GET: begin
                if (empty) begin
                    status = fqd_pkg::ST_EMPTY;
                end else begin
                    res_value   = cell_data[0];
                    count_next  = count_reg - 1'b1;
                end
            end
            fqd_pkg::CMD_DEL: begin
                if (found[fqd_pkg::DEPTH-1]) begin
                    res_value  = s_data.item_value;
                    count_next = count_reg - 1'b1;
                end else begin
                    status = fqd_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                status = fqd_pkg::ST_OK;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next             = 1'b1;
            m_data_next.result_value = res_value;
            m_data_next.status       = status;
            m_data_next.occupancy    = fqd_pkg::OCC_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // fill count never exceeds the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH))
        else $error("fill count above depth");

    // held result reports the current fill count
    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.occupancy == fqd_pkg::OCC_W'(count_reg))
        else $error("occupancy does not match fill count");

    // put on a full queue leaves the count alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.cmd == fqd_pkg::CMD_PUT && full
        |=> count_reg == $past(count_reg))
        else $error("count changed on full put");

    // get on a non-empty queue removes exactly one entry
    a_get_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.cmd == fqd_pkg::CMD_GET && !empty
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("get did not remove one entry");

    // a delete that reports ok removes exactly one entry
    a_del_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.cmd == fqd_pkg::CMD_DEL && found[fqd_pkg::DEPTH-1]
        |=> count_reg == $past(count_reg) - 1'b1 && m_data_reg.status == fqd_pkg::ST_OK)
        else $error("delete did not remove one entry");
`endif

endmodule
